/* hdl/min_bond_harmonic_force_core_assert.svh */
// assertion macros for the shortest-bond harmonic force block
// used by the top level only
`ifndef MIN_BOND_HARMONIC_FORCE_CORE_ASSERT_SVH
`define MIN_BOND_HARMONIC_FORCE_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define MBH_ASSERT_IMPL(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error(msg);
// implication whose right side is checked in the cycle after the left side
`define MBH_ASSERT_NEXT(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

/* hdl/mbhf_pkg.sv */
// shared types and constants for the shortest-bond harmonic force block
// no dependencies
`default_nettype none
package mbhf_pkg;
    localparam int DATA_W = 32;
    localparam int LSQ_W  = 64;
    localparam int ROOT_W = 32;
    localparam int CFG_AW = 4;
    localparam logic [CFG_AW-1:0] ADDR_K_GAIN      = 4'h0;
    localparam logic [CFG_AW-1:0] ADDR_REST_LENGTH = 4'h4;
    localparam logic [CFG_AW-1:0] ADDR_FORCE_LIMIT = 4'h8;

    // shared multiplier phases
    localparam logic [2:0] PH_RK     = 3'd0;  // k times stretch
    localparam logic [2:0] PH_FX     = 3'd1;
    localparam logic [2:0] PH_FY     = 3'd2;
    localparam logic [2:0] PH_FZ     = 3'd3;
    localparam logic [2:0] PH_EN_LO  = 3'd4;  // low half of rk times stretch
    localparam logic [2:0] PH_EN_HI  = 3'd5;  // high half of rk times stretch
    localparam logic [2:0] PH_MAG    = 3'd6;  // latch clamped magnitude

    // controller to datapath commands
    typedef struct packed {
        logic accept;      // take an input word into the tracker
        logic start_eval;  // latch winner and begin finishing
        logic sqrt_step;   // one square root iteration
        logic div_init;    // load divider
        logic div_step;    // one divider iteration
        logic mul_step;    // one multiply step, index in the phase field
        logic [2:0] phase;
        logic finish;      // form result word
    } mbhf_cmd_t;

    typedef struct packed {
        logic applied;
        logic zero_root;
    } mbhf_status_t;
endpackage
`default_nettype wire

/* hdl/min_bond_harmonic_force_core.sv */
// top level of the shortest-bond harmonic force block
// depends on mbhf_pkg, mbhf_ctrl, mbhf_datapath and the assertion header
`default_nettype none
// Bonds of one group arrive one word per cycle while the block is idle; the
// shortest is tracked on the fly, so non-last words never hold off input. On
// the word marked last (tlast) the block stops taking input while it latches
// the winner, runs a 32-step bit-serial square root, forms r-r0, does one
// multiply for k*dr, a 64-step restoring divide of k*dr by r, latches the
// clamped magnitude and makes six more passes through one shared 32x32
// multiplier (k*dr again, since the divider shifts its copy out, the three
// force components and two halves of the energy), then forms the result and
// loads it. The result word then sits in an output register until taken; the
// next group's words are accepted meanwhile, but a second result waits in
// the finish step, with input held off, until the first has gone.
`include "min_bond_harmonic_force_core_assert.svh"
module min_bond_harmonic_force_core #(
    parameter int FRAC_BITS = 16,
    parameter int ATOM_BITS = 20
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // delta_x, delta_y, delta_z, atom_a, atom_b, zero fill
    input  wire logic [((96 + 2*ATOM_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // applied, target_a, target_b, force_x, force_y, force_z, energy, zero fill
    output logic [((129 + 2*ATOM_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mbhf_pkg::*;

    localparam int OW = ((129 + 2*ATOM_BITS + 7) / 8) * 8;

    logic [31:0] k_gain_reg;
    logic [30:0] rest_length_reg;
    logic [30:0] force_limit_reg;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_gain_reg <= '0;
            rest_length_reg <= '0;
            force_limit_reg <= 31'h7FFF_FFFF;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                ADDR_K_GAIN:      k_gain_reg <= pwdata;
                ADDR_REST_LENGTH: rest_length_reg <= pwdata[30:0];
                ADDR_FORCE_LIMIT: force_limit_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr)
            ADDR_K_GAIN:      prdata = k_gain_reg;
            ADDR_REST_LENGTH: prdata = {1'b0, rest_length_reg};
            ADDR_FORCE_LIMIT: prdata = {1'b0, force_limit_reg};
            default:          prdata = '0;
        endcase
    end

    mbhf_cmd_t    cmd;
    mbhf_status_t status;
    logic in_ready, out_load, in_fire;
    logic res_applied;
    logic [ATOM_BITS-1:0] res_a, res_b;
    logic [31:0] res_fx, res_fy, res_fz, res_energy;
    logic m_valid_reg;
    logic [OW-1:0] m_data_reg;

    assign s_tready = in_ready;
    assign in_fire = s_tvalid && s_tready;

    mbhf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .in_last(s_tlast),
        .out_busy(m_valid_reg), .status(status), .cmd(cmd),
        .in_ready(in_ready), .out_load(out_load)
    );

    mbhf_datapath #(.FRAC_BITS(FRAC_BITS), .ATOM_BITS(ATOM_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .in_dx(s_tdata[31:0]), .in_dy(s_tdata[63:32]), .in_dz(s_tdata[95:64]),
        .in_a(s_tdata[96 +: ATOM_BITS]), .in_b(s_tdata[96+ATOM_BITS +: ATOM_BITS]),
        .k_gain(k_gain_reg), .rest_length(rest_length_reg),
        .force_limit(force_limit_reg),
        .res_applied(res_applied), .res_a(res_a), .res_b(res_b),
        .res_fx(res_fx), .res_fy(res_fy), .res_fz(res_fz), .res_energy(res_energy)
    );

    // output register; controller waits in finish until it is empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= OW'({res_energy, res_fz, res_fy, res_fx, res_b, res_a, res_applied});
        end
    end
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

    `MBH_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, out_load, !m_valid_reg, "result overwritten")
    `MBH_ASSERT_NEXT(a_load_valid, aclk, aresetn, out_load, m_tvalid, "load without valid")
    `MBH_ASSERT_IMPL(a_busy_no_in, aclk, aresetn, cmd.sqrt_step || cmd.div_step, !s_tready, "input taken while busy")
endmodule
`default_nettype wire

/* hdl/mbhf_datapath.sv */
// datapath: shortest-bond tracker, bit-serial root and divider, shared multiplier
// depends on mbhf_pkg
`default_nettype none
module mbhf_datapath #(
    parameter int FRAC_BITS = 16,
    parameter int ATOM_BITS = 20
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire mbhf_pkg::mbhf_cmd_t     cmd,
    output mbhf_pkg::mbhf_status_t       status,
    input  wire logic [31:0]             in_dx,
    input  wire logic [31:0]             in_dy,
    input  wire logic [31:0]             in_dz,
    input  wire logic [ATOM_BITS-1:0]    in_a,
    input  wire logic [ATOM_BITS-1:0]    in_b,
    input  wire logic [31:0]             k_gain,
    input  wire logic [30:0]             rest_length,
    input  wire logic [30:0]             force_limit,
    output logic                         res_applied,
    output logic [ATOM_BITS-1:0]         res_a,
    output logic [ATOM_BITS-1:0]         res_b,
    output logic [31:0]                  res_fx,
    output logic [31:0]                  res_fy,
    output logic [31:0]                  res_fz,
    output logic [31:0]                  res_energy
);
    import mbhf_pkg::*;

    // tracker
    logic [63:0] best_lsq_reg;
    logic [31:0] best_dx_reg, best_dy_reg, best_dz_reg;
    logic [ATOM_BITS-1:0] best_a_reg, best_b_reg;
    // evaluation
    logic [63:0] lsq_reg;
    logic [31:0] ex_reg, ey_reg, ez_reg;
    logic        app_reg;
    logic [63:0] rem_reg;       // sqrt remainder
    logic [31:0] root_reg;
    logic [63:0] rk_reg;
    logic [31:0] dr_reg;
    logic [63:0] drem_reg;      // divider partial remainder
    logic [63:0] quo_reg;
    logic [31:0] mag_reg;
    logic [95:0] en_reg;

    logic [31:0] ax, ay, az;
    logic [63:0] sq_x, sq_y, sq_z;
    logic [63:0] lsq_in;
    logic [61:0] thr;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        abs32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    assign ax = abs32(in_dx);
    assign ay = abs32(in_dy);
    assign az = abs32(in_dz);
    assign sq_x = {32'd0, ax} * {32'd0, ax};
    assign sq_y = {32'd0, ay} * {32'd0, ay};
    assign sq_z = {32'd0, az} * {32'd0, az};
    // three squares of at most 2^62 each never carry out of 64 bits
    assign lsq_in = sq_x + sq_y + sq_z;
    assign thr = {31'd0, rest_length} * {31'd0, rest_length};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_lsq_reg <= '1;
        end else if (cmd.accept) begin
            if (lsq_in < best_lsq_reg) begin
                best_lsq_reg <= lsq_in;
            end
        end else if (cmd.start_eval) begin
            best_lsq_reg <= '1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_dx_reg <= '0; best_dy_reg <= '0; best_dz_reg <= '0;
            best_a_reg <= '0; best_b_reg <= '0;
        end else if (cmd.accept && lsq_in < best_lsq_reg) begin
            best_dx_reg <= in_dx; best_dy_reg <= in_dy; best_dz_reg <= in_dz;
            best_a_reg <= in_a; best_b_reg <= in_b;
        end else if (cmd.start_eval) begin
            best_dx_reg <= '0; best_dy_reg <= '0; best_dz_reg <= '0;
            best_a_reg <= '0; best_b_reg <= '0;
        end
    end

    // sqrt: restoring, two bits of radicand per step
    logic [65:0] sq_trial;
    logic [65:0] sq_partial;
    assign sq_partial = {rem_reg, lsq_reg[63:62]};
    assign sq_trial   = sq_partial - {32'd0, root_reg, 2'b01};

    // divider: rk / r bit-serial on rk, remainder check done at end
    logic [64:0] dv_shift;
    logic [64:0] dv_trial;
    assign dv_shift = {drem_reg, rk_reg[63]};
    assign dv_trial = dv_shift - {33'd0, root_reg};

    // shared multiplier 32x32
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    always_comb begin
        case (cmd.phase)
            PH_RK:    begin mul_a = k_gain;        mul_b = dr_reg;  end
            PH_FX:    begin mul_a = abs32(ex_reg); mul_b = mag_reg; end
            PH_FY:    begin mul_a = abs32(ey_reg); mul_b = mag_reg; end
            PH_FZ:    begin mul_a = abs32(ez_reg); mul_b = mag_reg; end
            PH_EN_LO: begin mul_a = rk_reg[31:0];  mul_b = dr_reg;  end
            PH_EN_HI: begin mul_a = rk_reg[63:32]; mul_b = dr_reg;  end
            default:  begin mul_a = '0;            mul_b = '0;      end
        endcase
    end
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // force component from product and sign of delta
    function automatic logic [31:0] fcomp(input logic [63:0] p, input logic neg);
        logic [63:0] pr;
        logic [31:0] r;
        pr = p >> FRAC_BITS;
        if (neg) begin
            r = (pr > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : pr[31:0];
        end else begin
            r = (pr > 64'h8000_0000) ? 32'h8000_0000 : (~pr[31:0] + 32'd1);
        end
        fcomp = r;
    endfunction

    // magnitude 2q, rounded up when twice the remainder reaches r, then clamped
    logic [63:0] q_lim;
    logic [31:0] mag_raw;
    logic [31:0] mag_sel;
    always_comb begin
        q_lim = quo_reg;
        mag_raw = {q_lim[30:0], 1'b0};
        mag_sel = '0;
        if (root_reg != '0) begin
            if (q_lim >= 64'h8000_0000) mag_sel = {1'b0, force_limit};
            else mag_sel = mag_raw
                + (({drem_reg, 1'b0} >= {33'd0, root_reg}) ? 32'd1 : 32'd0);
        end
        if (mag_sel > {1'b0, force_limit}) mag_sel = {1'b0, force_limit};
    end

    logic [95:0] en_shift;
    assign en_shift = en_reg >> (2 * FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (cmd.start_eval) begin
            lsq_reg <= best_lsq_reg;
            ex_reg <= best_dx_reg; ey_reg <= best_dy_reg; ez_reg <= best_dz_reg;
            res_a <= best_a_reg; res_b <= best_b_reg;
            app_reg <= best_lsq_reg >= {2'b0, thr};
            rem_reg <= '0;
            root_reg <= '0;
            mag_reg <= '0;
            rk_reg <= '0;
            en_reg <= '0;
        end
        if (cmd.sqrt_step) begin
            lsq_reg <= {lsq_reg[61:0], 2'b00};
            if (!sq_trial[65]) begin
                rem_reg <= sq_trial[63:0];
                root_reg <= {root_reg[30:0], 1'b1};
            end else begin
                rem_reg <= sq_partial[63:0];
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
        if (cmd.div_init) begin
            drem_reg <= '0;
            quo_reg <= '0;
            dr_reg <= (root_reg >= {1'b0, rest_length}) ? root_reg - {1'b0, rest_length} : '0;
        end
        if (cmd.mul_step) begin
            case (cmd.phase)
                PH_RK:    rk_reg <= mul_p;
                PH_FX:    res_fx <= (mag_reg == '0) ? '0 : fcomp(mul_p, ex_reg[31]);
                PH_FY:    res_fy <= (mag_reg == '0) ? '0 : fcomp(mul_p, ey_reg[31]);
                PH_FZ:    res_fz <= (mag_reg == '0) ? '0 : fcomp(mul_p, ez_reg[31]);
                PH_EN_LO: en_reg <= {32'd0, mul_p};
                PH_EN_HI: en_reg <= en_reg + {mul_p, 32'd0};
                default:  en_reg <= en_reg;
            endcase
        end
        if (cmd.div_step) begin
            rk_reg <= {rk_reg[62:0], 1'b0};
            if (!dv_trial[64]) begin
                drem_reg <= dv_trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                drem_reg <= dv_shift[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
        if (cmd.phase == PH_MAG && cmd.mul_step) begin
            mag_reg <= mag_sel;
        end
        if (cmd.finish) begin
            res_applied <= app_reg;
            if (!app_reg) begin
                res_fx <= '0; res_fy <= '0; res_fz <= '0; res_energy <= '0;
            end else begin
                res_energy <= (en_shift[95:32] != '0) ? 32'hFFFF_FFFF : en_shift[31:0];
            end
        end
    end

    assign status.applied   = app_reg;
    assign status.zero_root = (root_reg == '0);
endmodule
`default_nettype wire

/* hdl/mbhf_ctrl.sv */
// controller: sequences accept, root, divide and multiply phases
// depends on mbhf_pkg
`default_nettype none
module mbhf_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_fire,
    input  wire logic                in_last,
    input  wire logic                out_busy,
    input  wire mbhf_pkg::mbhf_status_t status,
    output mbhf_pkg::mbhf_cmd_t      cmd,
    output logic                     in_ready,
    output logic                     out_load
);
    import mbhf_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LATCH = 4'd1;
    localparam logic [3:0] ST_SQRT  = 4'd2;
    localparam logic [3:0] ST_DINIT = 4'd3;
    localparam logic [3:0] ST_RK    = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_MAG   = 4'd6;
    localparam logic [3:0] ST_MULS  = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.accept = in_fire;
                if (in_fire && in_last) state_next = ST_LATCH;
            end
            ST_LATCH: begin
                cmd.start_eval = 1'b1;
                cnt_next = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd31) state_next = ST_DINIT;
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                state_next = ST_RK;
            end
            ST_RK: begin
                cmd.mul_step = 1'b1;
                cmd.phase = PH_RK;
                cnt_next = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) state_next = ST_MAG;
            end
            ST_MAG: begin
                // latch the clamped magnitude from quotient and remainder
                cmd.mul_step = 1'b1;
                cmd.phase = PH_MAG;
                state_next = ST_MULS;
                cnt_next = 7'd0;
            end
            ST_MULS: begin
                // rk was shifted out by the divider; recompute it for energy first
                cmd.mul_step = 1'b1;
                case (cnt_reg[2:0])
                    3'd0: cmd.phase = PH_RK;
                    3'd1: cmd.phase = PH_FX;
                    3'd2: cmd.phase = PH_FY;
                    3'd3: cmd.phase = PH_FZ;
                    3'd4: cmd.phase = PH_EN_LO;
                    default: cmd.phase = PH_EN_HI;
                endcase
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd5) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                out_load = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    logic unused;
    assign unused = ^{status.applied, status.zero_root};
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// self-checking testbench for min_bond_harmonic_force_core
// depends on mbhf_pkg and the block's rtl; a predictor built into the bench supplies every result
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import mbhf_pkg::*;

    localparam int S_W = ((96 + 2*20 + 7) / 8) * 8;
    localparam int M_W = ((129 + 2*20 + 7) / 8) * 8;
    localparam logic [3:0] ADDR_UNUSED = 4'hC;
    localparam int IDLE_PCT = 13;
    localparam int SETTLE_CYCLES = 150;

    typedef struct {
        logic        applied;
        logic [19:0] target_a;
        logic [19:0] target_b;
        logic [31:0] force_x;
        logic [31:0] force_y;
        logic [31:0] force_z;
        logic [31:0] energy;
    } bond_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // delta_x, delta_y, delta_z, atom_a, atom_b, zero fill
    logic [S_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // applied, target_a, target_b, force_x, force_y, force_z, energy, zero fill
    logic [M_W-1:0] m_tdata;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    min_bond_harmonic_force_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // generous fixed limit, far beyond the slowest correct run
    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    // predictor copy of the registers
    logic [31:0] spring_k;
    logic [30:0] rest_len;
    logic [30:0] force_cap;

    // predictor copy of the shortest-bond tracker
    logic [63:0] short_lsq;
    logic [31:0] short_dx, short_dy, short_dz;
    logic [19:0] short_a, short_b;

    bond_result_t pending_results[$];
    int  fail_count = 0;
    bit  steady = 1'b0;        // when set, neither side idles
    int  stall_request = 0;    // receiver hold-off length, picked up by the receiver

    function automatic logic [63:0] magnitude(logic [31:0] v);
        return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // force on atom a is minus the displacement scaled by the magnitude
    function automatic logic [31:0] scaled_force(logic [31:0] d, logic [63:0] mag);
        logic [63:0] prod;
        prod = (magnitude(d) * mag) >> 16;
        if (mag == 0 || prod == 0) return 32'd0;
        if (d[31]) return (prod > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : prod[31:0];
        if (prod > 64'h8000_0000) prod = 64'h8000_0000;
        return 32'(64'h1_0000_0000 - prod);
    endfunction

    task automatic clear_tracker();
        short_lsq = '1;
        short_dx = 0; short_dy = 0; short_dz = 0;
        short_a = 0; short_b = 0;
    endtask

    // one accepted bond; closes the group on the last word
    task automatic track_bond(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                              logic [19:0] a, logic [19:0] b, logic last);
        logic [63:0] lsq, root, dr, rk, mag, quo, rem;
        logic [127:0] e;
        bond_result_t res;
        lsq = magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy)
            + magnitude(dz) * magnitude(dz);
        if (lsq < short_lsq) begin
            short_lsq = lsq;
            short_dx = dx; short_dy = dy; short_dz = dz;
            short_a = a; short_b = b;
        end
        if (!last) return;
        res.applied = short_lsq >= {33'd0, rest_len} * {33'd0, rest_len};
        res.target_a = short_a;
        res.target_b = short_b;
        res.force_x = 0; res.force_y = 0; res.force_z = 0; res.energy = 0;
        if (res.applied) begin
            root = floor_sqrt(short_lsq);
            dr = (root >= rest_len) ? root - rest_len : 0;
            rk = {32'd0, spring_k} * dr;
            mag = 0;
            if (root > 0) begin
                quo = rk / root;
                rem = rk % root;
                if (quo >= 64'h8000_0000) mag = force_cap;
                else mag = 2 * quo + ((2 * rem >= root) ? 1 : 0);
            end
            if (mag > force_cap) mag = force_cap;
            res.force_x = scaled_force(short_dx, mag);
            res.force_y = scaled_force(short_dy, mag);
            res.force_z = scaled_force(short_dz, mag);
            e = ({64'd0, rk} * {64'd0, dr}) >> 32;
            res.energy = (e > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
        end
        pending_results.push_back(res);
        clear_tracker();
    endtask

    // apb write: setup cycle then access cycle
    task automatic reg_write(logic [3:0] addr, logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_K_GAIN) spring_k = value;
        else if (addr == ADDR_REST_LENGTH) rest_len = value[30:0];
        else if (addr == ADDR_FORCE_LIMIT) force_cap = value[30:0];
    endtask

    task automatic set_coeffs(logic [31:0] k, logic [31:0] r0, logic [31:0] fmax);
        reg_write(ADDR_K_GAIN, k);
        reg_write(ADDR_REST_LENGTH, r0);
        reg_write(ADDR_FORCE_LIMIT, fmax);
    endtask

    // offers one bond word and waits for the handshake
    task automatic send_bond(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                             logic [19:0] a, logic [19:0] b, logic last);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, a, dz, dy, dx};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_bond(dx, dy, dz, a, b, last);
    endtask

    // sender pauses until every expected result is back, then lets the block settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_delta();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
            2: return 32'($urandom_range(0, 32'h400)) - 32'h200;
            3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return 32'($urandom_range(0, 32'h3_0000)) - 32'h1_8000;
        endcase
    endfunction

    // one group with random content; sometimes repeats a bond to make a tie
    task automatic send_random_group(int bonds);
        logic [31:0] dx, dy, dz;
        dx = pick_delta(); dy = pick_delta(); dz = pick_delta();
        for (int i = 0; i < bonds; i++) begin
            if (i == 0 || $urandom_range(4) != 0) begin
                dx = pick_delta(); dy = pick_delta(); dz = pick_delta();
            end else begin
                dx = -dx;  // same length, later in the group
            end
            send_bond(dx, dy, dz, 20'($urandom), 20'($urandom), i == bonds - 1);
        end
    endtask

    function automatic int pick_group_size();
        return ($urandom_range(19) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    endfunction

    // receiver: random idling, plus a long hold-off on request
    always @(posedge aclk) begin
        int hold_left;
        if (stall_request > 0) begin
            hold_left = stall_request;
            stall_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    // result checker, compares each accepted word with the oldest expectation
    always @(posedge aclk) begin
        bond_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("applied", want.applied, m_tdata[0]);
                check_field("target_a", want.target_a, m_tdata[20:1]);
                check_field("target_b", want.target_b, m_tdata[40:21]);
                check_field("force_x", want.force_x, m_tdata[72:41]);
                check_field("force_y", want.force_y, m_tdata[104:73]);
                check_field("force_z", want.force_z, m_tdata[136:105]);
                check_field("energy", want.energy, m_tdata[168:137]);
            end
        end
    end

    // reset values: k is zero so no force, largest cap, rest length zero
    task automatic test_reset_state();
        send_bond(32'h0001_0000, 32'h0, 32'h0, 20'h00001, 20'h00002, 1'b1);
        send_bond(32'h0, 32'h0, 32'h0, 20'hFFFFF, 20'h00000, 1'b1);
        wait_drained();
    endtask

    task automatic test_special_cases();
        set_coeffs(32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF);
        // below rest length: targets still name the shortest bond
        send_bond(32'h0000_8000, 32'h0, 32'h0, 20'h12345, 20'h54321, 1'b1);
        // shortest of three wins, stretched past rest length
        send_bond(32'h0004_0000, 32'h0, 32'h0, 20'h1, 20'h2, 1'b0);
        send_bond(32'h0, 32'hFFFE_0000, 32'h0, 20'h3, 20'h4, 1'b0);
        send_bond(32'h0, 32'h0, 32'h0003_0000, 20'h5, 20'h6, 1'b1);
        // tie: earliest of equal bonds stays
        send_bond(32'h0002_0000, 32'h0, 32'h0, 20'hAAAAA, 20'h55555, 1'b0);
        send_bond(32'h0, 32'h0, 32'hFFFE_0000, 20'h55555, 20'hAAAAA, 1'b1);
        // extremes of the displacement fields
        send_bond(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 20'hFFFFF, 20'hFFFFF, 1'b1);
        send_bond(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'h0, 20'hFFFFF, 1'b1);
        send_bond(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 20'hFFFFF, 20'h0, 1'b1);
        wait_drained();
        // zero length with zero rest length: applied yet no force
        set_coeffs(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
        send_bond(32'h0, 32'h0, 32'h0, 20'h00F0F, 20'hF0F00, 1'b1);
        send_bond(32'h0000_0001, 32'h0, 32'h0, 20'h1, 20'h1, 1'b1);
        send_bond(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 20'h2, 20'h3, 1'b1);
        wait_drained();
        // force cap at zero, and writes to an unused address are ignored
        set_coeffs(32'h0010_0000, 32'h0000_8000, 32'h0);
        reg_write(ADDR_UNUSED, 32'hFFFF_FFFF);
        send_bond(32'h0005_0000, 32'hFFFB_0000, 32'h0, 20'h7, 20'h8, 1'b1);
        wait_drained();
        // largest rest length: nothing but the extreme vectors reach it
        set_coeffs(32'h0001_0000, 32'h7FFF_FFFF, 32'h0001_0000);
        send_bond(32'h8000_0000, 32'h8000_0000, 32'h0, 20'h9, 20'hA, 1'b1);
        send_bond(32'h0001_0000, 32'h0, 32'h0, 20'hB, 20'hC, 1'b1);
        wait_drained();
    endtask

    // a range of coefficient sets, the extremes among them
    task automatic test_coefficient_sweep(int groups_per_set);
        logic [31:0] ks[5] = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0100, 32'h0};
        logic [31:0] rs[5] = '{32'h0001_0000, 32'h0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0};
        logic [31:0] fs[5] = '{32'h7FFF_FFFF, 32'h0, 32'h0100_0000, 32'h7FFF_FFFF, 32'h1};
        for (int s = 0; s < 5; s++) begin
            set_coeffs(ks[s], rs[s], fs[s]);
            for (int g = 0; g < groups_per_set; g++) send_random_group(pick_group_size());
            wait_drained();
        end
    endtask

    // random coefficients in phases, one stretch with no idling on either side
    task automatic test_random_groups(int bonds_wanted);
        int sent;
        int phase_bonds;
        int size;
        sent = 0;
        while (sent < bonds_wanted) begin
            set_coeffs($urandom_range(3) == 0 ? $urandom : $urandom_range(0, 32'h0004_0000),
                       $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 32'h0002_0000),
                       $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 32'h0100_0000));
            steady = (sent > bonds_wanted / 2) && (sent < bonds_wanted / 2 + 250);
            phase_bonds = 0;
            while (phase_bonds < 150) begin
                size = pick_group_size();
                send_random_group(size);
                phase_bonds += size;
            end
            sent += phase_bonds;
            wait_drained();
            steady = 1'b0;
        end
    endtask

    // receiver holds off long while groups keep coming, so the input stalls
    task automatic test_output_stall();
        set_coeffs(32'h0002_0000, 32'h0000_8000, 32'h0800_0000);
        stall_request = 600;
        for (int g = 0; g < 20; g++) send_random_group($urandom_range(1, 4));
        wait_drained();
    endtask

    initial begin
        clear_tracker();
        spring_k = 0;
        rest_len = 0;
        force_cap = 31'h7FFF_FFFF;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_special_cases();
        test_coefficient_sweep(12);
        test_output_stall();
        test_random_groups(1150);
        wait_drained();
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
